// File: hdl/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold whenever the trigger holds
`define SOA_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("allocator check failed");

// condition must hold in the cycle after the trigger
`define SOA_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("allocator check failed");

`endif

// File: hdl/soa_pkg.sv
// shared types, constants and helpers of the slab object allocator
package soa_pkg;

  localparam int MAX_SLABS = 64;
  localparam int MAX_SLOTS = 64;
  localparam int SLAB_W = 6;
  localparam int SLOT_W = 6;
  localparam int PTR_W = 7;
  localparam int CNT_W = 7;
  localparam int USE_W = 13;

  localparam logic [PTR_W-1:0] NIL = 7'h40;

  // list identifiers
  localparam logic [1:0] L_FREE = 2'd0;
  localparam logic [1:0] L_PART = 2'd1;
  localparam logic [1:0] L_FULL = 2'd2;

  // result codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSLAB = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  // register indexes
  localparam logic REG_OBJECTS_PER_SLAB = 1'b0;
  localparam logic REG_SLAB_LIMIT = 1'b1;

  // datapath commands
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_TAKE = 4'd1;
  localparam logic [3:0] OP_READ = 4'd2;
  localparam logic [3:0] OP_LINK = 4'd3;
  localparam logic [3:0] OP_UPD = 4'd4;
  localparam logic [3:0] OP_CREATE = 4'd5;
  localparam logic [3:0] OP_M0 = 4'd6;
  localparam logic [3:0] OP_M1 = 4'd7;
  localparam logic [3:0] OP_M2 = 4'd8;
  localparam logic [3:0] OP_M3 = 4'd9;
  localparam logic [3:0] OP_EMIT = 4'd10;

  typedef struct packed {
    logic req_type;
    logic [SLAB_W-1:0] slab_index;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [SLAB_W-1:0] got_slab;
    logic [SLOT_W-1:0] got_slot;
    logic [USE_W-1:0] objects_in_use;
    logic [CNT_W-1:0] slabs_created;
  } rsp_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic in_free;
    logic has_list;
    logic can_create;
    logic bad_slab;
    logic upd_bad;
    logic move;
    logic out_ready;
  } stat_t;

  // per-slab bookkeeping word
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] fresh;
    logic [CNT_W-1:0] fcnt;
    logic [CNT_W-1:0] total;
  } info_t;

  // list that a slab belongs on for its free count
  function automatic logic [1:0] list_of(input logic [CNT_W-1:0] fc,
                                         input logic [CNT_W-1:0] tot);
    logic [1:0] l;
    if (fc == tot) l = L_FREE;
    else if (fc == '0) l = L_FULL;
    else l = L_PART;
    return l;
  endfunction

endpackage

// File: hdl/slab_object_allocator.sv
// top level of the slab object allocator
// one request at a time: on a pool failure or bad slab the result skips the
// memory passes, otherwise it waits on the read and write-back passes over
// the single-port slab and list memories
// the next request is taken in the cycle after the result is loaded
// synchronous reset empties all lists and counters; slot rows need no clear,
// each slab's row is written when that slab is created, with slot 0 marked taken
`include "assert_macros.svh"
module slab_object_allocator import soa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output rsp_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  // sequencer
  soa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  soa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  // checks
  `SOA_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  `SOA_ASSERT_NOW(a_status_code, clk, rst, out_valid, out_data.status != 2'd3)
  `SOA_ASSERT_NOW(a_slab_count, clk, rst, out_valid,
                  out_data.slabs_created <= CNT_W'(MAX_SLABS))

endmodule

// File: hdl/soa_ctrl.sv
// sequencing state machine of the slab object allocator
module soa_ctrl import soa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_LINK = 4'd2;
  localparam logic [3:0] S_UPD = 4'd3;
  localparam logic [3:0] S_CREATE = 4'd4;
  localparam logic [3:0] S_M0 = 4'd5;
  localparam logic [3:0] S_M1 = 4'd6;
  localparam logic [3:0] S_M2 = 4'd7;
  localparam logic [3:0] S_M3 = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_TAKE;
          if (st.in_free) state_next = st.bad_slab ? S_DONE : S_READ;
          else if (st.has_list) state_next = S_READ;
          else if (st.can_create) state_next = S_CREATE;
          else state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.op = OP_READ;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.op = OP_LINK;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op = OP_UPD;
        state_next = (!st.upd_bad && st.move) ? S_M0 : S_DONE;
      end
      S_CREATE: begin
        cmd.op = OP_CREATE;
        state_next = S_M2;
      end
      S_M0: begin
        cmd.op = OP_M0;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.op = OP_M1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.op = OP_M2;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.op = OP_M3;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_ready) begin
          cmd.op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// File: hdl/soa_dp.sv
// memories, list heads, counters and result register of the allocator
module soa_dp import soa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output rsp_t       out_data,
  input  cmd_t       cmd,
  output stat_t      st
);

  // configuration and control state
  logic [CNT_W-1:0] objects_per_slab, slab_limit;
  logic [PTR_W-1:0] head_free, head_part, head_full;
  logic [CNT_W-1:0] created;
  logic [USE_W-1:0] in_use;

  // transaction registers
  logic              rq_free;
  logic [SLAB_W-1:0] s;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        res_status;
  logic [1:0]        from_l, to_l;
  logic [PTR_W-1:0]  hreg;

  // memories and their read registers
  logic [PTR_W-1:0]     next_mem [MAX_SLABS];
  logic [PTR_W-1:0]     prev_mem [MAX_SLABS];
  info_t                info_mem [MAX_SLABS];
  logic [MAX_SLOTS-1:0] row_mem  [MAX_SLABS];
  logic [PTR_W-1:0]     link_mem [MAX_SLABS*MAX_SLOTS];
  logic [PTR_W-1:0]     next_q, prev_q, link_q;
  info_t                info_q;
  logic [MAX_SLOTS-1:0] row_q;

  // clamped configuration
  logic [CNT_W-1:0] lim, tot_new;
  assign lim = (slab_limit > CNT_W'(MAX_SLABS)) ? CNT_W'(MAX_SLABS) : slab_limit;
  assign tot_new = (objects_per_slab == '0) ? CNT_W'(1) :
                   (objects_per_slab > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) :
                   objects_per_slab;

  // decisions at request time
  logic has_list, can_create, bad_slab;
  assign has_list = (head_part != NIL) || (head_free != NIL);
  assign can_create = (created < lim);
  assign bad_slab = ({1'b0, in_data.slab_index} >= created);

  // slot update on the fetched slab
  logic             use_stack, bit_set;
  logic [SLOT_W-1:0] a_slot;
  info_t            info_new;
  logic [MAX_SLOTS-1:0] row_new;
  always_comb begin
    use_stack = (info_q.head != NIL);
    a_slot = use_stack ? info_q.head[SLOT_W-1:0] : info_q.fresh[SLOT_W-1:0];
    bit_set = row_q[slot];
    info_new = info_q;
    row_new = row_q;
    if (rq_free) begin
      row_new[slot] = 1'b0;
      info_new.head = {1'b0, slot};
      info_new.fcnt = info_q.fcnt + CNT_W'(1);
    end else begin
      row_new[a_slot] = 1'b1;
      info_new.head = use_stack ? link_q : info_q.head;
      info_new.fresh = use_stack ? info_q.fresh : info_q.fresh + CNT_W'(1);
      info_new.fcnt = info_q.fcnt - CNT_W'(1);
    end
  end

  logic upd_bad;
  logic [1:0] from_now, to_now;
  assign upd_bad = rq_free && !bit_set;
  assign from_now = list_of(info_q.fcnt, info_q.total);
  assign to_now = list_of(info_new.fcnt, info_new.total);

  // status to the controller
  always_comb begin
    st.in_free = (in_data.req_type == REQ_FREE);
    st.has_list = has_list;
    st.can_create = can_create;
    st.bad_slab = bad_slab;
    st.upd_bad = upd_bad;
    st.move = (from_now != to_now);
    st.out_ready = !out_valid || !out_stall;
  end

  // head of a list by identifier
  logic [PTR_W-1:0] head_to;
  always_comb begin
    case (to_l)
      L_FREE: head_to = head_free;
      L_PART: head_to = head_part;
      default: head_to = head_full;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      objects_per_slab <= CNT_W'(64);
      slab_limit <= CNT_W'(64);
      head_free <= NIL;
      head_part <= NIL;
      head_full <= NIL;
      created <= '0;
      in_use <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OBJECTS_PER_SLAB) objects_per_slab <= cfg_data;
        else slab_limit <= cfg_data;
      end
      // result valid: set on emit, cleared once taken
      if (cmd.op == OP_EMIT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (cmd.op)
        OP_UPD: begin
          if (!upd_bad) in_use <= rq_free ? in_use - USE_W'(1) : in_use + USE_W'(1);
        end
        OP_CREATE: begin
          created <= created + CNT_W'(1);
          in_use <= in_use + USE_W'(1);
        end
        OP_M1: begin
          if (prev_q == NIL) begin
            case (from_l)
              L_FREE: head_free <= next_q;
              L_PART: head_part <= next_q;
              default: head_full <= next_q;
            endcase
          end
        end
        OP_M3: begin
          case (to_l)
            L_FREE: head_free <= {1'b0, s};
            L_PART: head_part <= {1'b0, s};
            default: head_full <= {1'b0, s};
          endcase
        end
        default: ;
      endcase
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAKE: begin
        rq_free <= in_data.req_type;
        slot <= in_data.slot_index;
        res_status <= ST_OK;
        if (in_data.req_type == REQ_FREE) begin
          s <= in_data.slab_index;
          if (bad_slab) res_status <= ST_BADFREE;
        end else if (head_part != NIL) begin
          s <= head_part[SLAB_W-1:0];
        end else if (head_free != NIL) begin
          s <= head_free[SLAB_W-1:0];
        end else begin
          s <= created[SLAB_W-1:0];
          if (!can_create) res_status <= ST_NOSLAB;
        end
      end
      OP_UPD: begin
        from_l <= from_now;
        to_l <= to_now;
        if (!rq_free) slot <= a_slot;
        if (upd_bad) res_status <= ST_BADFREE;
      end
      OP_CREATE: begin
        slot <= '0;
        to_l <= (tot_new == CNT_W'(1)) ? L_FULL : L_PART;
      end
      OP_M2: hreg <= head_to;
      OP_EMIT: begin
        out_data.status <= res_status;
        out_data.got_slab <= (res_status == ST_OK && !rq_free) ? s : '0;
        out_data.got_slot <= (res_status == ST_OK && !rq_free) ? slot : '0;
        out_data.objects_in_use <= in_use;
        out_data.slabs_created <= created;
      end
      default: ;
    endcase
  end

  // per-slab info and allocation rows
  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ) begin
      info_q <= info_mem[s];
      row_q <= row_mem[s];
    end
    if (cmd.op == OP_UPD && !upd_bad) begin
      info_mem[s] <= info_new;
      row_mem[s] <= row_new;
    end else if (cmd.op == OP_CREATE) begin
      info_mem[s] <= '{head: NIL, fresh: CNT_W'(1), fcnt: tot_new - CNT_W'(1),
                       total: tot_new};
      row_mem[s] <= MAX_SLOTS'(1);
    end
  end

  // freed-slot stack links
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LINK) link_q <= link_mem[{s, info_q.head[SLOT_W-1:0]}];
    if (cmd.op == OP_UPD && rq_free && !upd_bad) link_mem[{s, slot}] <= info_q.head;
  end

  // list link memories
  always_ff @(posedge clk) begin
    if (cmd.op == OP_M0) begin
      next_q <= next_mem[s];
      prev_q <= prev_mem[s];
    end
    if (cmd.op == OP_M1 && prev_q != NIL) next_mem[prev_q[SLAB_W-1:0]] <= next_q;
    else if (cmd.op == OP_M2) next_mem[s] <= head_to;
    if (cmd.op == OP_M1 && next_q != NIL) prev_mem[next_q[SLAB_W-1:0]] <= prev_q;
    else if (cmd.op == OP_M2) prev_mem[s] <= NIL;
    else if (cmd.op == OP_M3 && hreg != NIL) prev_mem[hreg[SLAB_W-1:0]] <= {1'b0, s};
  end

endmodule
